/* sv/block_decomposed_range_sum_macros.svh */
// ----------------------------------------------------------------------------
// block_decomposed_range_sum macros
// assertion shorthands clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BLOCK_DECOMPOSED_RANGE_SUM_MACROS_SVH
`define BLOCK_DECOMPOSED_RANGE_SUM_MACROS_SVH

// same-cycle implication
`define BDRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bdrs_pkg.sv */
// ----------------------------------------------------------------------------
// bdrs_pkg
// shared sizes and the controller to datapath command word
// ----------------------------------------------------------------------------
package bdrs_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int BLOCK_LEN    = 32;
    localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam int ELEM_AW      = $clog2(MAX_ELEMENTS);
    localparam int BLK_W        = $clog2(BLOCK_LEN);
    localparam int BLK_AW       = ELEM_AW - BLK_W;
    localparam int COUNT_W      = 11;
    localparam int DATA_W       = 32;
    localparam int BSUM_W       = 38;
    localparam int SUM_W        = 42;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               load;
        logic               elem_rd;
        logic               elem_wr;
        logic               bsum_rd;
        logic               bsum_wr;
        logic               wr_zero;
        logic               add_elem;
        logic               add_bsum;
        logic [ELEM_AW-1:0] elem_addr;
        logic [BLK_AW-1:0]  bsum_addr;
    } dp_cmd_t;

endpackage

/* sv/bdrs_datapath.sv */
// ----------------------------------------------------------------------------
// bdrs_datapath
// element memory, block sum memory, block sum update and query accumulator
// ----------------------------------------------------------------------------
module bdrs_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bdrs_pkg::dp_cmd_t                     cmd,
    input  logic signed [bdrs_pkg::DATA_W-1:0]    value,
    output logic signed [bdrs_pkg::SUM_W-1:0]     range_sum
);

    logic signed [bdrs_pkg::DATA_W-1:0] elem_mem [bdrs_pkg::MAX_ELEMENTS];
    logic signed [bdrs_pkg::BSUM_W-1:0] bsum_mem [bdrs_pkg::NUM_BLOCKS];

    logic signed [bdrs_pkg::DATA_W-1:0] elem_rd_reg;
    logic signed [bdrs_pkg::BSUM_W-1:0] bsum_rd_reg;
    logic signed [bdrs_pkg::DATA_W-1:0] value_reg;

    logic                               add_elem_reg;
    logic                               add_bsum_reg;
    logic signed [bdrs_pkg::SUM_W-1:0]  acc_reg;
    logic signed [bdrs_pkg::SUM_W-1:0]  acc_next;

    logic signed [bdrs_pkg::DATA_W-1:0] elem_wr_data;
    logic signed [bdrs_pkg::BSUM_W-1:0] bsum_new;
    logic signed [bdrs_pkg::BSUM_W-1:0] bsum_wr_data;

    assign bsum_new = bsum_rd_reg + bdrs_pkg::BSUM_W'(value_reg)
                      - bdrs_pkg::BSUM_W'(elem_rd_reg);
    assign elem_wr_data = cmd.wr_zero ? '0 : value_reg;
    assign bsum_wr_data = cmd.wr_zero ? '0 : bsum_new;

    always_ff @(posedge clk)
    begin
        if (cmd.elem_wr)
        begin
            elem_mem[cmd.elem_addr] <= elem_wr_data;
        end
        if (cmd.elem_rd)
        begin
            elem_rd_reg <= elem_mem[cmd.elem_addr];
        end
        if (cmd.bsum_wr)
        begin
            bsum_mem[cmd.bsum_addr] <= bsum_wr_data;
        end
        if (cmd.bsum_rd)
        begin
            bsum_rd_reg <= bsum_mem[cmd.bsum_addr];
        end
        if (cmd.load)
        begin
            value_reg <= value;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load)
        begin
            acc_next = '0;
        end
        else if (add_elem_reg)
        begin
            acc_next = acc_reg + bdrs_pkg::SUM_W'(elem_rd_reg);
        end
        else if (add_bsum_reg)
        begin
            acc_next = acc_reg + bdrs_pkg::SUM_W'(bsum_rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_elem_reg <= 1'b0;
            add_bsum_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            add_elem_reg <= cmd.add_elem;
            add_bsum_reg <= cmd.add_bsum;
            acc_reg      <= acc_next;
        end
    end

    assign range_sum = acc_reg;

endmodule

/* sv/bdrs_ctrl.sv */
// ----------------------------------------------------------------------------
// bdrs_ctrl
// sequencer for clearing, element writes and range walks
// ----------------------------------------------------------------------------
`include "block_decomposed_range_sum_macros.svh"

module bdrs_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                mode,
    input  logic [bdrs_pkg::ELEM_AW-1:0]        index,
    input  logic [bdrs_pkg::ELEM_AW-1:0]        left,
    input  logic [bdrs_pkg::ELEM_AW-1:0]        right,
    input  logic                                cfg_valid,
    input  logic [bdrs_pkg::COUNT_W-1:0]        cfg_data,
    output logic                                busy,
    output logic                                done,
    output logic                                accepted,
    output bdrs_pkg::dp_cmd_t                   cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_READ,
        ST_WR_UPDATE,
        ST_Q_HEAD,
        ST_Q_MID,
        ST_Q_TAIL,
        ST_DRAIN
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [bdrs_pkg::ELEM_AW-1:0]    ptr_reg;
    logic [bdrs_pkg::ELEM_AW-1:0]    ptr_next;
    logic [bdrs_pkg::BLK_AW-1:0]     blk_reg;
    logic [bdrs_pkg::BLK_AW-1:0]     blk_next;
    logic [bdrs_pkg::ELEM_AW-1:0]    right_reg;
    logic [bdrs_pkg::ELEM_AW-1:0]    right_next;
    logic [bdrs_pkg::COUNT_W-1:0]    count_reg;
    logic [bdrs_pkg::COUNT_W-1:0]    count_next;
    logic                            done_reg;
    logic                            done_next;
    logic                            accepted_reg;
    logic                            accepted_next;

    logic [bdrs_pkg::COUNT_W-1:0]    live_n;
    logic                            accept;
    logic                            wr_ok;
    logic                            q_ok;
    logic                            item_ok;
    logic [bdrs_pkg::BLK_AW-1:0]     eb;
    logic [bdrs_pkg::BLK_AW-1:0]     ptr_blk;
    logic [bdrs_pkg::BLK_AW:0]       ptr_blk_inc;
    logic [bdrs_pkg::BLK_AW:0]       blk_inc;

    assign live_n = (count_reg > bdrs_pkg::COUNT_W'(bdrs_pkg::MAX_ELEMENTS))
                    ? bdrs_pkg::COUNT_W'(bdrs_pkg::MAX_ELEMENTS) : count_reg;
    assign accept  = start && (state_reg == ST_IDLE);
    assign wr_ok   = bdrs_pkg::COUNT_W'(index) < live_n;
    assign q_ok    = (bdrs_pkg::COUNT_W'(right) < live_n) && (left <= right);
    assign item_ok = (mode == bdrs_pkg::MODE_WRITE) ? wr_ok : q_ok;

    assign eb          = right_reg[bdrs_pkg::ELEM_AW-1 -: bdrs_pkg::BLK_AW];
    assign ptr_blk     = ptr_reg[bdrs_pkg::ELEM_AW-1 -: bdrs_pkg::BLK_AW];
    assign ptr_blk_inc = {1'b0, ptr_blk} + (bdrs_pkg::BLK_AW+1)'(1);
    assign blk_inc     = {1'b0, blk_reg} + (bdrs_pkg::BLK_AW+1)'(1);

    assign count_next = cfg_valid ? cfg_data : count_reg;

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        blk_next      = blk_reg;
        right_next    = right_reg;
        done_next     = 1'b0;
        accepted_next = accepted_reg;
        cmd           = '0;
        cmd.elem_addr = ptr_reg;
        cmd.bsum_addr = ptr_blk;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.elem_wr   = 1'b1;
                cmd.wr_zero   = 1'b1;
                cmd.bsum_wr   = ptr_reg < bdrs_pkg::ELEM_AW'(bdrs_pkg::NUM_BLOCKS);
                cmd.bsum_addr = ptr_reg[bdrs_pkg::BLK_AW-1:0];
                ptr_next      = ptr_reg + 1'b1;
                if (ptr_reg == bdrs_pkg::ELEM_AW'(bdrs_pkg::MAX_ELEMENTS - 1))
                begin
                    state_next = ST_IDLE;
                    ptr_next   = '0;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (!item_ok)
                    begin
                        done_next     = 1'b1;
                        accepted_next = 1'b0;
                    end
                    else if (mode == bdrs_pkg::MODE_WRITE)
                    begin
                        ptr_next   = index;
                        state_next = ST_WR_READ;
                    end
                    else
                    begin
                        ptr_next   = left;
                        right_next = right;
                        state_next = ST_Q_HEAD;
                    end
                end
            end

            ST_WR_READ:
            begin
                cmd.elem_rd = 1'b1;
                cmd.bsum_rd = 1'b1;
                state_next  = ST_WR_UPDATE;
            end

            ST_WR_UPDATE:
            begin
                cmd.elem_wr   = 1'b1;
                cmd.bsum_wr   = 1'b1;
                done_next     = 1'b1;
                accepted_next = 1'b1;
                state_next    = ST_IDLE;
            end

            ST_Q_HEAD:
            begin
                cmd.elem_rd  = 1'b1;
                cmd.add_elem = 1'b1;
                ptr_next     = ptr_reg + 1'b1;
                if (ptr_reg == right_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else if (&ptr_reg[bdrs_pkg::BLK_W-1:0])
                begin
                    if (ptr_blk_inc < {1'b0, eb})
                    begin
                        blk_next   = ptr_blk_inc[bdrs_pkg::BLK_AW-1:0];
                        state_next = ST_Q_MID;
                    end
                    else
                    begin
                        state_next = ST_Q_TAIL;
                    end
                end
            end

            ST_Q_MID:
            begin
                cmd.bsum_rd   = 1'b1;
                cmd.add_bsum  = 1'b1;
                cmd.bsum_addr = blk_reg;
                blk_next      = blk_inc[bdrs_pkg::BLK_AW-1:0];
                if (blk_inc == {1'b0, eb})
                begin
                    ptr_next   = {eb, {bdrs_pkg::BLK_W{1'b0}}};
                    state_next = ST_Q_TAIL;
                end
            end

            ST_Q_TAIL:
            begin
                cmd.elem_rd  = 1'b1;
                cmd.add_elem = 1'b1;
                ptr_next     = ptr_reg + 1'b1;
                if (ptr_reg == right_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                done_next     = 1'b1;
                accepted_next = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            blk_reg      <= '0;
            right_reg    <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            blk_reg      <= blk_next;
            right_reg    <= right_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            accepted_reg <= accepted_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign accepted = accepted_reg;

    `BDRS_ASSERT_NEXT(a_reject_now, accept && !item_ok, done_reg && !accepted_reg, "rejected word not reported next cycle")
    `BDRS_ASSERT_NOW(a_ok_source, done_reg && accepted_reg, $past(state_reg == ST_DRAIN || state_reg == ST_WR_UPDATE), "accepted result without finished work")
    `BDRS_ASSERT_NOW(a_mid_range, state_reg == ST_Q_MID, blk_reg < eb, "block walk past last block")
    `BDRS_ASSERT_NOW(a_ptr_range, (state_reg == ST_Q_HEAD) || (state_reg == ST_Q_TAIL), ptr_reg <= right_reg, "element walk past range end")

endmodule

/* sv/block_decomposed_range_sum.sv */
// ----------------------------------------------------------------------------
// block_decomposed_range_sum
// point update and range sum over an element store split into blocks
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start, busy             mode, index, value, left, right
//  result    done (one-cycle strobe) range_sum, accepted
//  config    cfg_valid, cfg_ready    cfg_data (element count)
//
//  after reset a clearing pass zeroes both memories; busy is high
//  a write passes a read and an update state; a rejected word gets done next cycle
//  a query reads each element of its first and last block and one block sum per
//  whole block in between, then drains; elements come through the single read port
//  the next word is taken in the cycle the done strobe shows
//  results cannot be stalled; cfg_ready is always high
// ----------------------------------------------------------------------------
module block_decomposed_range_sum
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [bdrs_pkg::ELEM_AW-1:0]        index,
    input  logic signed [bdrs_pkg::DATA_W-1:0]  value,
    input  logic [bdrs_pkg::ELEM_AW-1:0]        left,
    input  logic [bdrs_pkg::ELEM_AW-1:0]        right,
    output logic                                done,
    output logic signed [bdrs_pkg::SUM_W-1:0]   range_sum,
    output logic                                accepted,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdrs_pkg::COUNT_W-1:0]        cfg_data
);

    bdrs_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    bdrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .index     (index),
        .left      (left),
        .right     (right),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .done      (done),
        .accepted  (accepted),
        .cmd       (cmd)
    );

    bdrs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .range_sum (range_sum)
    );

endmodule
